// File: hdl/tjq_pkg.sv
// Shared types and codes for the timed job queue.
// No dependencies; compiled first.
package tjq_pkg;

    localparam int DEPTH_DEF    = 16;
    localparam int TAG_BITS_DEF = 8;

    localparam int OP_W     = 2;
    localparam int TAG_W    = 8;
    localparam int TIME_W   = 32;
    localparam int DUE_W    = 33;
    localparam int STATUS_W = 3;
    localparam int QCOUNT_W = 5;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam logic [STATUS_W-1:0] ST_INSERTED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REMOVED    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DISPATCHED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NONE       = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [TAG_W-1:0]  job_tag;
        logic [TIME_W-1:0] submit_time;
        logic [TIME_W-1:0] start_delay;
        logic [TIME_W-1:0] now_time;
    } t_job_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TAG_W-1:0]    out_tag;
        logic [DUE_W-1:0]    due_time;
        logic [QCOUNT_W-1:0] queue_count;
        logic                last_result;
    } t_job_res;

endpackage

// File: hdl/tjq_stream_if.sv
// Valid/ready channel carrying one payload of type T per transaction.
// Used with tjq_pkg payload structs.
interface tjq_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/timed_job_queue.sv
// Timed job queue: top level with the job memory and its sequencer.
// Depends on tjq_pkg and tjq_stream_if.

// Holds up to DEPTH jobs sorted by due time (submit_time + start_delay, 33 bits),
// equal due times kept in arrival order. All jobs live in one memory with one
// write port and one registered read port, used as a ring with a head pointer,
// so removing the head only moves the pointer. An insert reads each held job
// with a later due time and writes it one slot further, one entry per cycle
// through the memory port, then writes the new job into the slot left free;
// a tick reads the new head from the memory once per dispatched job. Only one
// transaction is in work at a time: i_job.ready is high while the sequencer is
// idle, and results leave through an output register, so a new job is taken
// while the last result still waits on o_res. Operation code 3 is dropped
// without a result.
// No reset-time clearing is needed: only entries below the job count are read.
module timed_job_queue #(
    parameter int DEPTH    = tjq_pkg::DEPTH_DEF,
    parameter int TAG_BITS = tjq_pkg::TAG_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tjq_stream_if.sink   i_job,
    tjq_stream_if.source o_res
);
    import tjq_pkg::*;

    localparam int AW = $clog2(DEPTH);      // memory address
    localparam int CW = $clog2(DEPTH + 1);  // job count, 0..DEPTH

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INS  = 3'd1;   // insertion sort step
    localparam logic [2:0] S_POP  = 3'd2;   // head read back for remove
    localparam logic [2:0] S_TICK = 3'd3;   // head read back for dispatch test
    localparam logic [2:0] S_RESP = 3'd4;   // final result waits for output reg

    typedef struct packed {
        logic [DUE_W-1:0]    due;
        logic [TAG_BITS-1:0] tag;
    } t_entry;

    // job memory, one write and one registered read per cycle
    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr;
    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    t_entry        w_wr_data;

    // control state
    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_lpos, n_lpos;          // logical slot the new job may take

    // operands of the transaction in work
    logic [DUE_W-1:0]    r_new_due, n_new_due;
    logic [TAG_BITS-1:0] r_new_tag, n_new_tag;
    logic [TIME_W-1:0]   r_now, n_now;

    // result held back until it is known whether it is the last one
    logic                r_pend_valid, n_pend_valid;
    logic [STATUS_W-1:0] r_pend_status, n_pend_status;
    logic [TAG_BITS-1:0] r_pend_tag, n_pend_tag;
    logic [DUE_W-1:0]    r_pend_due, n_pend_due;
    logic [CW-1:0]       r_pend_count, n_pend_count;

    // output register
    logic     r_out_valid;
    t_job_res r_out;
    t_job_res w_out_data;
    logic     w_out_load;
    logic     w_out_last;
    logic     w_out_free;

    logic     w_in_ready;
    logic     w_in_fire;

    // width adapters between fixed port fields and parameterized storage
    logic [TAG_BITS+TAG_W-1:0]    w_in_tag_ext;
    logic [TAG_W+TAG_BITS-1:0]    w_out_tag_ext;
    logic [QCOUNT_W+CW-1:0]       w_out_cnt_ext;

    // ring index of logical position l
    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] head,
                                             input logic [AW-1:0] l);
        logic [AW:0] s;
        s = {1'b0, head} + {1'b0, l};
        if (s >= (AW+1)'(DEPTH)) begin
            s = s - (AW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    assign w_in_ready   = (r_state == S_IDLE);
    assign w_in_fire    = i_job.valid && w_in_ready;
    assign i_job.ready  = w_in_ready;
    assign w_out_free   = !r_out_valid || o_res.ready;
    assign w_in_tag_ext = {{TAG_BITS{1'b0}}, i_job.data.job_tag};

    // ---------------------------------------------------------------------
    // Sequencer. Read data comes from the registered read port; the
    // address written in a cycle is never the one read in that cycle, since
    // the insert shift writes slot l while reading slot l-2.
    // ---------------------------------------------------------------------
    always_comb begin
        n_state       = r_state;
        n_head        = r_head;
        n_count       = r_count;
        n_lpos        = r_lpos;
        n_new_due     = r_new_due;
        n_new_tag     = r_new_tag;
        n_now         = r_now;
        n_pend_valid  = r_pend_valid;
        n_pend_status = r_pend_status;
        n_pend_tag    = r_pend_tag;
        n_pend_due    = r_pend_due;
        n_pend_count  = r_pend_count;
        w_rd_en       = 1'b0;
        w_rd_addr     = '0;
        w_wr_en       = 1'b0;
        w_wr_addr     = '0;
        w_wr_data     = '0;
        w_out_load    = 1'b0;
        w_out_last    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    n_new_due    = {1'b0, i_job.data.submit_time}
                                 + {1'b0, i_job.data.start_delay};
                    n_new_tag    = w_in_tag_ext[TAG_BITS-1:0];
                    n_now        = i_job.data.now_time;
                    n_pend_valid = 1'b0;
                    // default pending result: nothing to report
                    n_pend_status = ST_NONE;
                    n_pend_tag    = '0;
                    n_pend_due    = '0;
                    n_pend_count  = r_count;
                    case (i_job.data.operation)
                        OP_INSERT: begin
                            if (r_count == CW'(DEPTH)) begin
                                n_pend_status = ST_FULL;
                                n_state       = S_RESP;
                            end else begin
                                n_lpos = r_count[AW-1:0];
                                if (r_count != '0) begin
                                    w_rd_en   = 1'b1;
                                    w_rd_addr = f_phys(r_head, r_count[AW-1:0] - AW'(1));
                                end
                                n_state = S_INS;
                            end
                        end
                        OP_REMOVE, OP_TICK: begin
                            if (r_count == '0) begin
                                n_state = S_RESP;
                            end else begin
                                w_rd_en   = 1'b1;
                                w_rd_addr = r_head;
                                n_state   = (i_job.data.operation == OP_REMOVE) ? S_POP
                                                                                : S_TICK;
                            end
                        end
                        default: begin
                            // unused operation code: dropped
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_INS: begin
                if (r_lpos != '0 && r_rd_data.due > r_new_due) begin
                    // later job moves one slot toward the tail
                    w_wr_en   = 1'b1;
                    w_wr_addr = f_phys(r_head, r_lpos);
                    w_wr_data = r_rd_data;
                    if (r_lpos != AW'(1)) begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = f_phys(r_head, r_lpos - AW'(2));
                    end
                    n_lpos = r_lpos - AW'(1);
                end else begin
                    w_wr_en       = 1'b1;
                    w_wr_addr     = f_phys(r_head, r_lpos);
                    w_wr_data.due = r_new_due;
                    w_wr_data.tag = r_new_tag;
                    n_count       = r_count + CW'(1);
                    n_pend_status = ST_INSERTED;
                    n_pend_count  = r_count + CW'(1);
                    n_state       = S_RESP;
                end
            end

            S_POP: begin
                n_pend_status = ST_REMOVED;
                n_pend_tag    = r_rd_data.tag;
                n_pend_due    = r_rd_data.due;
                n_pend_count  = r_count - CW'(1);
                n_head        = f_phys(r_head, AW'(1));
                n_count       = r_count - CW'(1);
                n_state       = S_RESP;
            end

            S_TICK: begin
                if (r_rd_data.due <= {1'b0, r_now}) begin
                    // a new due head proves the pending one is not the last
                    if (!r_pend_valid || w_out_free) begin
                        w_out_load    = r_pend_valid;
                        n_pend_valid  = 1'b1;
                        n_pend_status = ST_DISPATCHED;
                        n_pend_tag    = r_rd_data.tag;
                        n_pend_due    = r_rd_data.due;
                        n_pend_count  = r_count - CW'(1);
                        n_head        = f_phys(r_head, AW'(1));
                        n_count       = r_count - CW'(1);
                        if (r_count != CW'(1)) begin
                            w_rd_en   = 1'b1;
                            w_rd_addr = f_phys(r_head, AW'(1));
                        end else begin
                            n_state = S_RESP;
                        end
                    end
                end else begin
                    // head not due: pending dispatch, or the 'none' result
                    // set up on acceptance, becomes the final one
                    n_state = S_RESP;
                end
            end

            S_RESP: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    w_out_last = 1'b1;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // Job memory
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // ---------------------------------------------------------------------
    // Control and operand registers
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_head       <= '0;
            r_count      <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head       <= n_head;
            r_count      <= n_count;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lpos        <= n_lpos;
        r_new_due     <= n_new_due;
        r_new_tag     <= n_new_tag;
        r_now         <= n_now;
        r_pend_status <= n_pend_status;
        r_pend_tag    <= n_pend_tag;
        r_pend_due    <= n_pend_due;
        r_pend_count  <= n_pend_count;
    end

    // ---------------------------------------------------------------------
    // Output register: always loaded from the pending result
    // ---------------------------------------------------------------------
    assign w_out_tag_ext = {{TAG_W{1'b0}}, r_pend_tag};
    assign w_out_cnt_ext = {{QCOUNT_W{1'b0}}, r_pend_count};

    always_comb begin
        w_out_data.status      = r_pend_status;
        w_out_data.out_tag     = w_out_tag_ext[TAG_W-1:0];
        w_out_data.due_time    = r_pend_due;
        w_out_data.queue_count = w_out_cnt_ext[QCOUNT_W-1:0];
        w_out_data.last_result = w_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out <= w_out_data;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

endmodule

// File: hdl/tjq_checker.sv
// Port-level checks for timed_job_queue, attached by bind.
// Depends on tjq_pkg.
module tjq_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic [1:0]        i_in_op,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input tjq_pkg::t_job_res i_out
);
    import tjq_pkg::*;

    // result stays offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out))
        else $error("result changed while stalled");

    // only dispatches can be followed by more results of the same transaction
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out.status != ST_DISPATCHED |-> i_out.last_result)
        else $error("single-result status without last flag");

    // a dispatched job was due at a 32-bit time
    a_dispatch_due: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out.status == ST_DISPATCHED |-> !i_out.due_time[DUE_W-1])
        else $error("dispatched job with due time beyond 32 bits");

    // one transaction in work at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_op != OP_UNUSED |=> !i_in_ready)
        else $error("new job taken while one is in work");

endmodule

bind timed_job_queue tjq_checker u_tjq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_job.valid),
    .i_in_ready  (i_job.ready),
    .i_in_op     (i_job.data.operation),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out       (o_res.data)
);
